[hdl/range_assign_range_max_tree_unit_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef RANGE_ASSIGN_RANGE_MAX_TREE_UNIT_MACROS_SVH
`define RANGE_ASSIGN_RANGE_MAX_TREE_UNIT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is low.
`define RAMT_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("range max unit check failed");

// Check a property on every rising edge, reset included.
`define RAMT_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("range max unit check failed");

`endif

[hdl/ramt_pkg.sv]
`default_nettype none
package ramt_pkg;
	localparam int KEY_W = 20;
	localparam int TAG_W = 30;
	localparam int IDX_W = 11;
	localparam int MAX_IDX = 2047;
	localparam int LC_RESET = 1024;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic REG_LEAF_COUNT = 1'b0;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} pair_t;

	typedef struct packed {
		logic             opcode;
		logic [IDX_W-1:0] range_low;
		logic [IDX_W-1:0] range_high;
		logic [KEY_W-1:0] assign_key;
		logic [TAG_W-1:0] assign_tag;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [KEY_W-1:0] max_key;
		logic [TAG_W-1:0] max_tag;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic load;
	} max_ctrl_t;
endpackage
`default_nettype wire

[hdl/ramt_mem.sv]
`default_nettype none
module ramt_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire ramt_pkg::pair_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output ramt_pkg::pair_t      rdata
);
	import ramt_pkg::*;

	pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/ramt_max.sv]
`default_nettype none
module ramt_max (
	input  wire logic                clk,
	input  wire ramt_pkg::max_ctrl_t ctrl,
	input  wire ramt_pkg::pair_t     pair,
	output ramt_pkg::pair_t          best
);
	import ramt_pkg::*;

	pair_t best_q;

	// keep the greater pair, key first then tag
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			best_q <= '0;
		end else if (ctrl.load && (pair > best_q)) begin
			best_q <= pair;
		end
	end

	assign best = best_q;
endmodule
`default_nettype wire

[hdl/range_assign_range_max_tree_unit.sv]
// Range assign / range maximum store. The block holds up to min(LEAVES, 2047)
// positions, numbered from 1, each holding a (key, tag) pair ordered by key
// and then by tag. An assign word writes its pair over every position from
// range_low to range_high and gives no result; a query word returns the
// greatest pair of the range with found set, or found clear and zeros when the
// range is empty. range_low of zero counts as 1 and range_high is clipped to
// leaf_count. Positions past leaf_count keep their pairs. After reset the
// store is cleared one position per cycle, and req_ready stays low while it
// clears (configuration writes are taken). A request then visits each
// position of its clipped range in turn, one position per cycle through the
// pair memory, and no new word is taken until it is done; an empty range
// visits none. A query result waits in an output register; the next word is
// taken only after the result has been loaded there.
`default_nettype none
module range_assign_range_max_tree_unit #(
	parameter int LEAVES = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire ramt_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output ramt_pkg::rsp_t        rsp,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ramt_pkg::*;

	localparam int DEPTH = (LEAVES < MAX_IDX) ? LEAVES : MAX_IDX;
	localparam int AW = $clog2(DEPTH);
	localparam int LC_RST = (LEAVES < LC_RESET) ? LEAVES : LC_RESET;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_ASSIGN, ST_READ, ST_DRAIN, ST_DONE
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_addr_q;
	logic [IDX_W-1:0] leaf_count_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] hi_q;
	pair_t            pair_q;
	logic             found_q;
	logic             rd_valid_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [IDX_W-1:0] lo_adj;
	logic [IDX_W-1:0] hi_adj;
	logic [IDX_W-1:0] idx_m1;
	logic [IDX_W-1:0] cfg_val;
	logic             accept;
	logic             cfg_wr;
	logic             rsp_load;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	pair_t            mem_wdata;
	pair_t            mem_rdata;
	pair_t            best;
	max_ctrl_t        max_ctrl;

	// APB register: leaf_count, clamped into 1..LEAVES on write
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_LEAF_COUNT);
	assign prdata  = {{(32-IDX_W){1'b0}}, leaf_count_q};
	assign cfg_val = pwdata[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= IDX_W'(LC_RST);
		end else if (cfg_wr) begin
			if (cfg_val == '0) begin
				leaf_count_q <= IDX_W'(1);
			end else if (32'(cfg_val) > 32'(LEAVES)) begin
				leaf_count_q <= IDX_W'(DEPTH);
			end else begin
				leaf_count_q <= cfg_val;
			end
		end
	end

	// clip the incoming range
	assign lo_adj = (req.range_low == '0) ? IDX_W'(1) : req.range_low;
	assign hi_adj = (req.range_high > leaf_count_q) ? leaf_count_q : req.range_high;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// load the output register once the previous result has left
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// pair memory: clear sweep or assign writes, query reads, never together
	assign idx_m1    = idx_q - IDX_W'(1);
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_ASSIGN);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : idx_m1[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : pair_q;

	ramt_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (state_q == ST_READ),
		.raddr(idx_m1[AW-1:0]),
		.rdata(mem_rdata)
	);

	// running maximum, cleared when a word is taken
	assign max_ctrl.clear = accept;
	assign max_ctrl.load  = rd_valid_s1;

	ramt_max u_max (
		.clk (clk),
		.ctrl(max_ctrl),
		.pair(mem_rdata),
		.best(best)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_q <= {req.assign_key, req.assign_tag};
			hi_q   <= hi_adj;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rd_valid_s1 <= (state_q == ST_READ);
			if (rsp_load) begin
				rsp_q       <= {found_q, best.key, best.tag};
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= lo_adj;
						found_q <= (lo_adj <= hi_adj);
						if (lo_adj > hi_adj) begin
							// empty range: drop an assign, answer a query without reading the memory
							state_q <= (req.opcode == OP_QUERY) ? ST_DONE : ST_IDLE;
						end else begin
							state_q <= (req.opcode == OP_QUERY) ? ST_READ : ST_ASSIGN;
						end
					end
				end
				ST_ASSIGN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == hi_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last read data folds into the maximum on this edge
					if (!rd_valid_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

[hdl/ramt_check.sv]
`default_nettype none
`include "range_assign_range_max_tree_unit_macros.svh"
module ramt_check (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire ramt_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire ramt_pkg::rsp_t rsp,
	input wire logic           pready
);
	import ramt_pkg::*;

	`RAMT_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	`RAMT_ASSERT(a_query_busy, clk, arst_n, req_valid && req_ready && (req.opcode == OP_QUERY) |=> !req_ready)
	`RAMT_ASSERT(a_rsp_after_busy, clk, arst_n, $rose(rsp_valid) |-> $past(!req_ready))
	`RAMT_ASSERT_ALWAYS(a_pready, clk, pready)
endmodule

bind range_assign_range_max_tree_unit ramt_check u_ramt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp),
	.pready   (pready)
);
`default_nettype wire
